@@ rtl/srw_pkg.sv @@
package srw_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam int WAVE_W = 32;
	localparam int FLUX_W = 32;
	localparam int PROD_W = 2 * FLUX_W;
	localparam int OUT_W = 48;
	localparam int SUM_SHIFT = 8;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_GRID = 2'd2;

	typedef struct packed {
		logic done;
		logic ovf;
		logic [FLUX_W-1:0] quo;
	} div_res_t;

endpackage

@@ rtl/srw_if.sv @@
interface srw_item_if import srw_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] cmd;
	logic [WAVE_W-1:0] wave;
	logic [FLUX_W-1:0] value;
	logic [WAVE_W-1:0] next_wave;
	logic last_item;

	modport source (output valid, cmd, wave, value, next_wave, last_item, input ready);
	modport sink (input valid, cmd, wave, value, next_wave, last_item, output ready);
endinterface

interface srw_result_if import srw_pkg::*; ();
	logic valid;
	logic ready;
	logic [OUT_W-1:0] weight_out;
	logic [FLUX_W-1:0] interp_flux;
	logic [WAVE_W-1:0] bin_width;
	logic was_clamped;
	logic status;

	modport source (output valid, weight_out, interp_flux, bin_width, was_clamped, status,
		input ready);
	modport sink (input valid, weight_out, interp_flux, bin_width, was_clamped, status,
		output ready);
endinterface

@@ rtl/srw_table.sv @@
module srw_table import srw_pkg::*; (
	input  logic clk,
	input  logic wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [WAVE_W-1:0] wr_wave,
	input  logic [FLUX_W-1:0] wr_flux,
	input  logic [IDX_W-1:0] rd_addr,
	output logic [WAVE_W-1:0] rd_wave,
	output logic [FLUX_W-1:0] rd_flux
);

	logic [WAVE_W-1:0] wave_mem [TABLE_DEPTH];
	logic [FLUX_W-1:0] flux_mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			wave_mem[wr_addr] <= wr_wave;
			flux_mem[wr_addr] <= wr_flux;
		end
		rd_wave <= wave_mem[rd_addr];
		rd_flux <= flux_mem[rd_addr];
	end

endmodule

@@ rtl/srw_div.sv @@
module srw_div import srw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [PROD_W-1:0] num,
	input  logic [FLUX_W-1:0] den,
	output div_res_t res
);

	localparam int STEP_W = $clog2(FLUX_W);

	logic run_q;
	logic done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [FLUX_W-1:0] rem_q;
	logic [FLUX_W-1:0] lo_q;
	logic [FLUX_W-1:0] den_q;
	logic ovf_q;
	logic [FLUX_W:0] shifted;
	logic [FLUX_W:0] diff;
	logic fits;

	assign shifted = {rem_q, lo_q[FLUX_W-1]};
	assign fits = shifted >= {1'b0, den_q};
	assign diff = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= run_q && !start && (cnt_q == STEP_W'(FLUX_W - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == STEP_W'(FLUX_W - 1))
					run_q <= 1'b0;
			end
		end
	end

	// one quotient bit per cycle, high half of the dividend preloaded as remainder
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[PROD_W-1:FLUX_W];
			lo_q <= num[FLUX_W-1:0];
			den_q <= den;
			ovf_q <= num[PROD_W-1:FLUX_W] >= den;
		end else if (run_q) begin
			rem_q <= fits ? diff[FLUX_W-1:0] : shifted[FLUX_W-1:0];
			lo_q <= {lo_q[FLUX_W-2:0], fits};
		end
	end

	assign res.done = done_q;
	assign res.ovf = ovf_q;
	assign res.quo = lo_q;

endmodule

@@ rtl/spectrum_resample_weight_unit.sv @@
// Spectrum resampling weight unit. Load a spectrum with append transactions (cmd 1, wavelength
// increasing), then send grid wavelengths (cmd 2) in increasing order; each grid transaction
// returns one result: the linearly interpolated flux at that wavelength (end segments
// extrapolated, negatives clamped to zero), the bin width, and weight * flux * width in Q32.16,
// saturating. A clear (cmd 0) empties the table and restarts the pass. Clear and append
// finish when accepted. A grid transaction also pays for every table entry the segment
// pointer steps over, with a table read state and a check state each; the shift-subtract
// divider and the single shared 32x32 multiplier, used four times per item (three when the
// divider is skipped), set the rest. Items that land on the segment's upper point, or on a
// flat or zero-length segment, skip the divider. A finished result waits in an output
// register, and the block takes no new transaction while it works on a grid item.
module spectrum_resample_weight_unit import srw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	srw_item_if.sink item,
	srw_result_if.source result
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_CHK,
		ST_RDHI,
		ST_RDLO,
		ST_CALC,
		ST_MUL,
		ST_DIVS,
		ST_DIVW,
		ST_PROD1,
		ST_PROD2,
		ST_PROD3,
		ST_SUM,
		ST_OUT
	} state_t;

	function automatic logic [WAVE_W-1:0] absdiff(input logic [WAVE_W-1:0] a,
		input logic [WAVE_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	state_t state_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] seg_q;
	logic [WAVE_W-1:0] prev_q;
	logic started_q;
	logic res_valid_q;

	logic [WAVE_W-1:0] w_q;
	logic [FLUX_W-1:0] val_q;
	logic last_q;
	logic [WAVE_W-1:0] width_q;
	logic [WAVE_W-1:0] l2_q;
	logic [FLUX_W-1:0] f2_q;
	logic neg_q;
	logic [FLUX_W-1:0] dff_q;
	logic [WAVE_W-1:0] dw_q;
	logic [WAVE_W-1:0] dl_q;
	logic [FLUX_W-1:0] flux_q;
	logic clamped_q;
	logic status_q;
	logic [PROD_W-1:0] mul_q;
	logic [PROD_W-1:0] p_q;
	logic [PROD_W-1:0] a_q;
	logic [OUT_W-1:0] wout_q;

	logic [OUT_W-1:0] res_wout_q;
	logic [FLUX_W-1:0] res_flux_q;
	logic [WAVE_W-1:0] res_width_q;
	logic res_clamped_q;
	logic res_status_q;

	logic accept;
	logic few;
	logic [IDX_W-1:0] top;
	logic [WAVE_W-1:0] width_in;
	logic wr_en;
	logic [IDX_W-1:0] rd_addr;
	logic [WAVE_W-1:0] rd_wave;
	logic [FLUX_W-1:0] rd_flux;
	logic [FLUX_W-1:0] mul_a;
	logic [FLUX_W-1:0] mul_b;
	logic special;
	logic load_out;
	logic [PROD_W-1:0] sum;
	logic [PROD_W-SUM_SHIFT-1:0] scaled;
	div_res_t div_res;

	assign item.ready = (state_q == ST_IDLE);
	assign accept = item.valid && item.ready;
	assign few = count_q < CNT_W'(2);
	assign top = IDX_W'(count_q - CNT_W'(1));
	assign wr_en = accept && (item.cmd == CMD_APPEND) && (count_q < CNT_W'(TABLE_DEPTH));
	assign rd_addr = (state_q == ST_RDLO) ? IDX_W'(seg_q - IDX_W'(1)) : seg_q;
	assign special = (rd_wave == l2_q) || (rd_flux == f2_q) || (w_q == l2_q);
	assign load_out = (state_q == ST_OUT) && (!res_valid_q || result.ready);
	assign sum = a_q + {{FLUX_W{1'b0}}, mul_q[PROD_W-1:FLUX_W]};
	assign scaled = sum[PROD_W-1:SUM_SHIFT];

	always_comb begin
		priority if (!started_q)
			width_in = absdiff(item.next_wave, item.wave);
		else if (item.last_item)
			width_in = absdiff(item.wave, prev_q);
		else
			width_in = absdiff(item.next_wave, prev_q) >> 1;
	end

	always_comb begin
		unique case (state_q)
			ST_MUL: begin
				mul_a = dff_q;
				mul_b = dw_q;
			end
			ST_PROD1: begin
				mul_a = val_q;
				mul_b = flux_q;
			end
			ST_PROD2: begin
				mul_a = mul_q[PROD_W-1:FLUX_W];
				mul_b = width_q;
			end
			ST_PROD3: begin
				mul_a = p_q[FLUX_W-1:0];
				mul_b = width_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	srw_table u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_wave (item.wave),
		.wr_flux (item.value),
		.rd_addr (rd_addr),
		.rd_wave (rd_wave),
		.rd_flux (rd_flux)
	);

	srw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_DIVS),
		.num    (mul_q),
		.den    (dl_q),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			seg_q <= '0;
			prev_q <= '0;
			started_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_out)
				res_valid_q <= 1'b1;
			else if (result.valid && result.ready)
				res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (item.cmd)
							CMD_CLEAR: begin
								count_q <= '0;
								seg_q <= '0;
								prev_q <= '0;
								started_q <= 1'b0;
							end
							CMD_APPEND: begin
								if (count_q < CNT_W'(TABLE_DEPTH))
									count_q <= count_q + CNT_W'(1);
							end
							CMD_GRID: begin
								if (item.last_item) begin
									started_q <= 1'b0;
									prev_q <= '0;
								end else begin
									started_q <= 1'b1;
									prev_q <= item.wave;
								end
								if (few) begin
									state_q <= ST_OUT;
								end else begin
									if (seg_q > top)
										seg_q <= top;
									state_q <= ST_RD;
								end
							end
							default: ;
						endcase
					end
				end
				ST_RD: state_q <= ST_CHK;
				ST_CHK: begin
					if ((seg_q < top) && (rd_wave < w_q)) begin
						seg_q <= seg_q + IDX_W'(1);
						state_q <= ST_RD;
					end else begin
						if (seg_q == '0)
							seg_q <= IDX_W'(1);
						state_q <= ST_RDHI;
					end
				end
				ST_RDHI: state_q <= ST_RDLO;
				ST_RDLO: state_q <= ST_CALC;
				ST_CALC: state_q <= special ? ST_PROD1 : ST_MUL;
				ST_MUL: state_q <= ST_DIVS;
				ST_DIVS: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (div_res.done)
						state_q <= ST_PROD1;
				end
				ST_PROD1: state_q <= ST_PROD2;
				ST_PROD2: state_q <= ST_PROD3;
				ST_PROD3: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_OUT;
				ST_OUT: begin
					if (load_out) begin
						if (last_q)
							seg_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					w_q <= item.wave;
					val_q <= item.value;
					last_q <= item.last_item;
					width_q <= width_in;
					flux_q <= '0;
					clamped_q <= 1'b0;
					status_q <= few;
					wout_q <= '0;
				end
			end
			ST_RDLO: begin
				l2_q <= rd_wave;
				f2_q <= rd_flux;
			end
			ST_CALC: begin
				// lower point arrives on the read port here
				dff_q <= absdiff(f2_q, rd_flux);
				dw_q <= absdiff(w_q, l2_q);
				dl_q <= absdiff(l2_q, rd_wave);
				neg_q <= (f2_q < rd_flux) ^ (w_q < l2_q) ^ (l2_q < rd_wave);
				if (special)
					flux_q <= f2_q;
			end
			ST_DIVW: begin
				if (div_res.done) begin
					if (neg_q) begin
						if (div_res.ovf || (div_res.quo > f2_q)) begin
							flux_q <= '0;
							clamped_q <= 1'b1;
						end else begin
							flux_q <= f2_q - div_res.quo;
						end
					end else begin
						if (div_res.ovf || (div_res.quo > ~f2_q))
							flux_q <= '1;
						else
							flux_q <= f2_q + div_res.quo;
					end
				end
			end
			ST_PROD2: p_q <= mul_q;
			ST_PROD3: a_q <= mul_q;
			ST_SUM: begin
				if (|scaled[PROD_W-SUM_SHIFT-1:OUT_W])
					wout_q <= '1;
				else
					wout_q <= scaled[OUT_W-1:0];
			end
			default: ;
		endcase
		if (load_out) begin
			res_wout_q <= wout_q;
			res_flux_q <= flux_q;
			res_width_q <= width_q;
			res_clamped_q <= clamped_q;
			res_status_q <= status_q;
		end
	end

	assign result.valid = res_valid_q;
	assign result.weight_out = res_wout_q;
	assign result.interp_flux = res_flux_q;
	assign result.bin_width = res_width_q;
	assign result.was_clamped = res_clamped_q;
	assign result.status = res_status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("point count past table depth");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHK) |-> (seg_q <= top))
		else $error("segment pointer past last point");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == ST_DIVW))
		else $error("divider finished outside its wait state");

	a_clamp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.was_clamped) |-> (result.interp_flux == '0))
		else $error("clamped flux not zero");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status) |->
		((result.weight_out == '0) && (result.interp_flux == '0) && !result.was_clamped))
		else $error("short table result not zero");

endmodule

@@ verif/tb_spectrum_resample_weight_unit.sv @@
module tb_spectrum_resample_weight_unit;
	import srw_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [WAVE_W-1:0] UM_ONE = 32'h0100_0000;
	localparam logic [FLUX_W-1:0] FX_ONE = 32'h0001_0000;
	localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};
	localparam longint unsigned LIMIT_NS = 64'd40_000_000;
	localparam int unsigned TARGET_ITEMS = 1650;

	typedef struct packed {
		logic [OUT_W-1:0] weight_out;
		logic [FLUX_W-1:0] interp_flux;
		logic [WAVE_W-1:0] bin_width;
		logic was_clamped;
		logic status;
	} srw_expect_t;

	class srw_scoreboard;
		logic [WAVE_W-1:0] wave_tab [TABLE_DEPTH];
		logic [FLUX_W-1:0] flux_tab [TABLE_DEPTH];
		int unsigned n_points;
		int unsigned seg_idx;
		logic [WAVE_W-1:0] prev_wave;
		bit started;
		srw_expect_t expected_q[$];
		int unsigned n_checked;
		int unsigned errors;

		function new();
			n_points = 0;
			seg_idx = 0;
			prev_wave = '0;
			started = 0;
			n_checked = 0;
			errors = 0;
		endfunction

		function logic [31:0] absdiff(logic [31:0] a, logic [31:0] b);
			return (a >= b) ? a - b : b - a;
		endfunction

		function logic [FLUX_W-1:0] flux_at(logic [WAVE_W-1:0] w, int unsigned lo,
				int unsigned hi, output bit clamped);
			logic [WAVE_W-1:0] l1, l2;
			logic [FLUX_W-1:0] f1, f2;
			logic [63:0] num, quo;
			bit neg;
			l1 = wave_tab[lo];
			l2 = wave_tab[hi];
			f1 = flux_tab[lo];
			f2 = flux_tab[hi];
			clamped = 0;
			if (l1 == l2 || f1 == f2 || w == l2)
				return f2;
			neg = (f2 < f1) ^ (w < l2) ^ (l2 < l1);
			num = 64'(absdiff(f2, f1)) * 64'(absdiff(w, l2));
			quo = num / 64'(absdiff(l2, l1));
			if (neg) begin
				if (quo > 64'(f2)) begin
					clamped = 1;
					return '0;
				end
				return f2 - quo[31:0];
			end
			if (quo > 64'(32'hFFFF_FFFF - f2))
				return '1;
			return f2 + quo[31:0];
		endfunction

		function logic [OUT_W-1:0] weighted(logic [FLUX_W-1:0] wt, logic [FLUX_W-1:0] fl,
				logic [WAVE_W-1:0] width);
			logic [63:0] p, a, b, s;
			p = 64'(wt) * 64'(fl);
			a = {32'b0, p[63:32]} * 64'(width);
			b = {32'b0, p[31:0]} * 64'(width);
			s = (a + (b >> 32)) >> SUM_SHIFT;
			if (s > 64'(OUT_MAX))
				return OUT_MAX;
			return s[OUT_W-1:0];
		endfunction

		// returns 1 when the transaction changes state or yields a result
		function bit note_item(logic [1:0] cmd, logic [WAVE_W-1:0] w, logic [FLUX_W-1:0] v,
				logic [WAVE_W-1:0] nw, logic last);
			srw_expect_t e;
			int unsigned top, j;
			bit clamped;
			case (cmd)
				CMD_CLEAR: begin
					n_points = 0;
					seg_idx = 0;
					prev_wave = '0;
					started = 0;
					return 1;
				end
				CMD_APPEND: begin
					if (n_points >= TABLE_DEPTH)
						return 0;
					wave_tab[n_points] = w;
					flux_tab[n_points] = v;
					n_points++;
					return 1;
				end
				CMD_GRID: begin
					e = '0;
					if (!started)
						e.bin_width = absdiff(nw, w);
					else if (last)
						e.bin_width = absdiff(w, prev_wave);
					else
						e.bin_width = absdiff(nw, prev_wave) >> 1;
					if (n_points < 2) begin
						e.status = 1'b1;
					end else begin
						top = n_points - 1;
						j = seg_idx;
						if (j > top)
							j = top;
						while (j < top && wave_tab[j] < w)
							j++;
						if (j == 0)
							j = 1;
						seg_idx = j;
						e.interp_flux = flux_at(w, j - 1, j, clamped);
						e.was_clamped = clamped;
						e.weight_out = weighted(v, e.interp_flux, e.bin_width);
					end
					if (last) begin
						started = 0;
						seg_idx = 0;
						prev_wave = '0;
					end else begin
						started = 1;
						prev_wave = w;
					end
					expected_q.push_back(e);
					return 1;
				end
				default: return 0;
			endcase
		endfunction

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			$display("result %0d: %s got %h expected %h", n_checked, what, got, want);
			errors++;
		endtask

		task check_result(srw_expect_t got);
			srw_expect_t want;
			if (expected_q.size() == 0) begin
				report_mismatch("result with no pending grid transaction", 64'(got), 64'd0);
			end else begin
				want = expected_q.pop_front();
				if (got.weight_out !== want.weight_out)
					report_mismatch("weight_out", 64'(got.weight_out), 64'(want.weight_out));
				if (got.interp_flux !== want.interp_flux)
					report_mismatch("interp_flux", 64'(got.interp_flux), 64'(want.interp_flux));
				if (got.bin_width !== want.bin_width)
					report_mismatch("bin_width", 64'(got.bin_width), 64'(want.bin_width));
				if (got.was_clamped !== want.was_clamped)
					report_mismatch("was_clamped", 64'(got.was_clamped), 64'(want.was_clamped));
				if (got.status !== want.status)
					report_mismatch("status", 64'(got.status), 64'(want.status));
			end
			n_checked++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	srw_item_if item_bus ();
	srw_result_if result_bus ();

	spectrum_resample_weight_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_bus),
		.result(result_bus)
	);

	srw_scoreboard sb = new();
	int unsigned counted = 0;
	bit send_calm = 0;
	int unsigned stall_left = 0;
	int unsigned calm_left = 0;
	logic [WAVE_W-1:0] tab_q[$];
	logic [FLUX_W-1:0] last_flux = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 20);
		return $urandom_range(30, 120);
	endfunction

	function logic [FLUX_W-1:0] pick_flux();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return last_flux;
		if (r < 5)
			return $urandom;
		return $urandom_range(0, 32'h00FF_FFFF);
	endfunction

	function logic [FLUX_W-1:0] pick_weight();
		if ($urandom_range(0, 1) == 0)
			return $urandom;
		return $urandom_range(0, 32'h0002_0000);
	endfunction

	// result side: random stalls, occasional long calm stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
			stall_left = 0;
			calm_left = 0;
		end else begin
			if (result_bus.valid && result_bus.ready)
				sb.check_result({result_bus.weight_out, result_bus.interp_flux,
					result_bus.bin_width, result_bus.was_clamped, result_bus.status});
			if (stall_left != 0) begin
				result_bus.ready <= 1'b0;
				stall_left--;
			end else begin
				result_bus.ready <= 1'b1;
				if (calm_left != 0)
					calm_left--;
				else if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap();
				else if ($urandom_range(0, 199) == 0)
					calm_left = $urandom_range(200, 2000);
			end
		end
	end

	task send_item(input logic [1:0] cmd, input logic [WAVE_W-1:0] w,
			input logic [FLUX_W-1:0] v, input logic [WAVE_W-1:0] nw, input logic last);
		int unsigned gap;
		gap = send_calm ? 0 : pick_gap();
		if (gap != 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.cmd <= cmd;
		item_bus.wave <= w;
		item_bus.value <= v;
		item_bus.next_wave <= nw;
		item_bus.last_item <= last;
		do
			@(posedge clk);
		while (!item_bus.ready);
		if (sb.note_item(cmd, w, v, nw, last))
			counted++;
	endtask

	task send_noise();
		send_item(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
			1'($urandom_range(0, 1)));
	endtask

	task grid_pass(input int unsigned m, input logic [WAVE_W-1:0] glo,
			input logic [WAVE_W-1:0] ghi, input bit finish);
		logic [WAVE_W-1:0] gq[$];
		logic [WAVE_W-1:0] nw;
		int unsigned k;
		gq = {};
		for (k = 0; k < m; k++) begin
			if (tab_q.size() != 0 && $urandom_range(0, 4) == 0)
				gq.push_back(tab_q[$urandom_range(0, tab_q.size() - 1)]);
			else
				gq.push_back($urandom_range(glo, ghi));
		end
		gq.sort();
		for (k = 0; k < m; k++) begin
			if ($urandom_range(0, 24) == 0)
				send_noise();
			nw = (k + 1 < m) ? gq[k + 1] : $urandom;
			if ($urandom_range(0, 9) == 0)
				nw = $urandom;
			send_item(CMD_GRID, gq[k], pick_weight(), nw, finish && (k == m - 1));
		end
	endtask

	task random_session();
		int unsigned n, m, k, r;
		logic [WAVE_W-1:0] tlo, thi;
		logic [WAVE_W-1:0] tq[$];
		send_calm = ($urandom_range(0, 5) == 0);
		if ($urandom_range(0, 9) != 0)
			send_item(CMD_CLEAR, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
		r = $urandom_range(0, 99);
		if (r < 4)
			n = $urandom_range(0, 1);
		else if (r < 90)
			n = $urandom_range(2, 12);
		else if (r < 98)
			n = $urandom_range(13, 64);
		else
			n = $urandom_range(65, 300);
		tlo = $urandom;
		if ($urandom_range(0, 3) == 0)
			thi = (tlo > 32'hFFF0_0000) ? '1 : tlo + $urandom_range(1, 32'h000F_FFFF);
		else
			thi = $urandom_range(tlo, 32'hFFFF_FFFF);
		tq = {};
		for (k = 0; k < n; k++)
			tq.push_back($urandom_range(tlo, thi));
		if ($urandom_range(0, 9) != 0)
			tq.sort();
		for (k = 1; k < n; k++)
			if ($urandom_range(0, 9) == 0)
				tq[k] = tq[k - 1];
		tab_q = tq;
		for (k = 0; k < n; k++) begin
			last_flux = pick_flux();
			send_item(CMD_APPEND, tq[k], last_flux, $urandom, 1'($urandom_range(0, 1)));
		end
		r = $urandom_range(0, 99);
		m = (r < 85) ? $urandom_range(1, 10) : $urandom_range(11, 40);
		grid_pass(m, $urandom_range(0, tlo), $urandom_range(thi, 32'hFFFF_FFFF),
			$urandom_range(0, 19) != 0);
		if ($urandom_range(0, 1) == 0)
			grid_pass($urandom_range(1, 8), $urandom_range(0, tlo),
				$urandom_range(thi, 32'hFFFF_FFFF), 1);
	endtask

	task directed_items();
		// empty table, then a single point
		send_item(CMD_GRID, UM_ONE, FX_ONE, 2 * UM_ONE, 1'b0);
		send_item(CMD_APPEND, UM_ONE, 2 * FX_ONE, '0, 1'b0);
		send_item(CMD_GRID, 2 * UM_ONE, FX_ONE, '1, 1'b1);
		// two points: below, on, between, on, beyond
		send_item(CMD_APPEND, 2 * UM_ONE, 4 * FX_ONE, '1, 1'b1);
		send_item(CMD_GRID, UM_ONE / 2, FX_ONE, UM_ONE, 1'b0);
		send_item(CMD_GRID, UM_ONE, FX_ONE, UM_ONE + UM_ONE / 2, 1'b0);
		send_item(CMD_GRID, UM_ONE + UM_ONE / 2, 2 * FX_ONE, 2 * UM_ONE, 1'b0);
		send_item(CMD_GRID, 2 * UM_ONE, FX_ONE, 3 * UM_ONE, 1'b0);
		send_item(CMD_GRID, 3 * UM_ONE, FX_ONE, 4 * UM_ONE, 1'b1);
		// falling segment extrapolated below zero, single-item pass
		send_item(CMD_CLEAR, '1, '1, '1, 1'b1);
		send_item(CMD_APPEND, UM_ONE, 4 * FX_ONE, '0, 1'b0);
		send_item(CMD_APPEND, 2 * UM_ONE, 2 * FX_ONE, '0, 1'b0);
		send_item(CMD_GRID, 4 * UM_ONE, FX_ONE, 5 * UM_ONE, 1'b1);
		// flux and product saturation at the field extremes
		send_item(CMD_CLEAR, '0, '0, '0, 1'b0);
		send_item(CMD_APPEND, '0, 32'hFFFF_0000, '0, 1'b0);
		send_item(CMD_APPEND, 32'h0000_0001, '1, '0, 1'b0);
		send_item(CMD_GRID, '1, '1, '0, 1'b1);
		// equal wavelengths on a segment
		send_item(CMD_CLEAR, '0, '0, '0, 1'b0);
		send_item(CMD_APPEND, UM_ONE, FX_ONE, '0, 1'b0);
		send_item(CMD_APPEND, UM_ONE, 3 * FX_ONE, '0, 1'b0);
		send_item(CMD_GRID, UM_ONE / 2, FX_ONE, UM_ONE, 1'b1);
		// points out of order, then an unknown command
		send_item(CMD_CLEAR, '0, '0, '0, 1'b0);
		send_item(CMD_APPEND, 3 * UM_ONE, FX_ONE, '0, 1'b0);
		send_item(CMD_APPEND, UM_ONE, 5 * FX_ONE, '0, 1'b0);
		send_item(CMD_GRID, 2 * UM_ONE, FX_ONE, '1, 1'b0);
		send_item(CMD_UNUSED, '1, '1, '1, 1'b1);
		send_item(CMD_GRID, '0, '0, '1, 1'b1);
	endtask

	task table_full_items();
		int unsigned k;
		send_calm = 1;
		send_item(CMD_CLEAR, '0, '0, '0, 1'b0);
		for (k = 0; k < TABLE_DEPTH + 4; k++)
			send_item(CMD_APPEND, WAVE_W'(k << 20), $urandom, $urandom, 1'b0);
		send_calm = 0;
		send_item(CMD_GRID, 32'h1000_0000, FX_ONE, 32'hFFF0_0000, 1'b0);
		send_item(CMD_GRID, 32'hFFF0_0000, FX_ONE, '1, 1'b0);
		send_item(CMD_GRID, '1, pick_weight(), '1, 1'b1);
	endtask

	initial begin
		arst_n = 1'b0;
		item_bus.valid = 1'b0;
		item_bus.cmd = CMD_CLEAR;
		item_bus.wave = '0;
		item_bus.value = '0;
		item_bus.next_wave = '0;
		item_bus.last_item = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_items();
		while (counted < TARGET_ITEMS)
			random_session();
		table_full_items();
		item_bus.valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0) begin
			$display("[spectrum_resample_weight_unit] OK");
		end else begin
			$display("[spectrum_resample_weight_unit] ERROR");
		end
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("timeout with %0d results pending", sb.expected_q.size());
		$display("[spectrum_resample_weight_unit] ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/srw_pkg.sv
rtl/srw_if.sv
rtl/srw_table.sv
rtl/srw_div.sv
rtl/spectrum_resample_weight_unit.sv
verif/tb_spectrum_resample_weight_unit.sv
